/* design/idbl_pkg.sv */
// ----------------------------------------------------------------------------
// idbl_pkg
// Shared widths, operation and status codes of the indexed block list.
// ----------------------------------------------------------------------------
package idbl_pkg;

  localparam int BLOCK_W         = 6;
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 7;
  localparam int POOL_BLOCKS_DEF = 64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_UNLINK = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2
  } status_t;

endpackage

/* design/idbl_if.sv */
// ----------------------------------------------------------------------------
// idbl_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface idbl_in_if;
  logic                         valid;
  logic                         ready;
  logic [idbl_pkg::OP_W-1:0]    operation;
  logic [idbl_pkg::BLOCK_W-1:0] block_index;

  modport source (output valid, output operation, output block_index, input ready);
  modport sink   (input valid, input operation, input block_index, output ready);
endinterface

interface idbl_out_if;
  logic                          valid;
  logic                          ready;
  logic [idbl_pkg::BLOCK_W-1:0]  returned_block;
  logic [idbl_pkg::STATUS_W-1:0] status;
  logic [idbl_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output returned_block, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input returned_block, input status, input entry_count,
                  output ready);
endinterface

/* design/indexed_doubly_linked_block_list.sv */
// ----------------------------------------------------------------------------
// indexed_doubly_linked_block_list
// Doubly linked list over a pool of numbered blocks: push at head, pop head,
// unlink any member. Links live in two memories, membership in flags.
// ----------------------------------------------------------------------------
// An accepted beat is read in S_IDLE and written back in S_EXEC. The accept
// edge reads the next and previous links of the addressed block (or of the
// head for a pop); the write-back edge writes at most one entry of each link
// memory, updates head, tail, count and membership, and loads the result
// register. A new beat is taken only after that, back in S_IDLE; the
// write-back is held while the result register still waits to be taken. Link
// memories need no clearing after reset, the membership flags clear at once.
// The link of a block toward the outside of the list (previous of the head,
// next of the tail) is never trusted and is taken as null.
module indexed_doubly_linked_block_list #(
  parameter int POOL_BLOCKS = idbl_pkg::POOL_BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  idbl_in_if.sink            in_chan,
  idbl_out_if.source         out_chan
);

  localparam int IDX_SPAN  = 2 ** idbl_pkg::BLOCK_W;
  localparam int MEM_DEPTH = (POOL_BLOCKS < IDX_SPAN) ? POOL_BLOCKS : IDX_SPAN;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int LINK_W    = $clog2(POOL_BLOCKS + 1);
  localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_BLOCKS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  logic [idbl_pkg::OP_W-1:0]     op_r;
  logic [idbl_pkg::BLOCK_W-1:0]  blk_r;
  logic [LINK_W-1:0]             head_r, head_nxt;
  logic [LINK_W-1:0]             tail_r, tail_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [idbl_pkg::BLOCK_W-1:0]  out_block_r;
  idbl_pkg::status_t             out_status_r;
  logic [idbl_pkg::COUNT_W-1:0]  out_count_r;

  logic                          accept;
  logic                          done;
  logic [ADDR_W-1:0]             rd_addr;
  logic [LINK_W-1:0]             next_rd, prev_rd;

  logic                          nwr_en, pwr_en;
  logic [ADDR_W-1:0]             nwr_addr, pwr_addr;
  logic [LINK_W-1:0]             nwr_data, pwr_data;

  logic                          member_rd;
  logic                          mset, mclr;
  logic [ADDR_W-1:0]             mwr_addr;

  logic [LINK_W-1:0]             blk_link, nx_link, pv_link;
  logic [ADDR_W-1:0]             blk_addr, head_addr;
  logic                          pool_hit;
  logic [idbl_pkg::BLOCK_W-1:0]  ret;
  idbl_pkg::status_t             status;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign done          = (state_r == S_EXEC) && (!out_valid_r || out_chan.ready);

  // pop reads the head's links, the others the named block's
  assign rd_addr = (in_chan.operation == idbl_pkg::OP_POP) ? head_r[ADDR_W-1:0]
                                                           : in_chan.block_index[ADDR_W-1:0];

  idbl_link_ram #(.DEPTH(MEM_DEPTH), .DATA_W(LINK_W)) u_next_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (next_rd),
    .wr_en   (nwr_en && done),
    .wr_addr (nwr_addr),
    .wr_data (nwr_data)
  );

  idbl_link_ram #(.DEPTH(MEM_DEPTH), .DATA_W(LINK_W)) u_prev_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (prev_rd),
    .wr_en   (pwr_en && done),
    .wr_addr (pwr_addr),
    .wr_data (pwr_data)
  );

  idbl_member_bits #(.DEPTH(MEM_DEPTH)) u_member (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (blk_addr),
    .rd_bit  (member_rd),
    .set_en  (mset && done),
    .clr_en  (mclr && done),
    .wr_addr (mwr_addr)
  );

  assign blk_link  = LINK_W'(blk_r);
  assign blk_addr  = blk_r[ADDR_W-1:0];
  assign head_addr = head_r[ADDR_W-1:0];
  assign pool_hit  = (32'(blk_r) < POOL_BLOCKS);

  always_comb begin
    nwr_en   = 1'b0;
    nwr_addr = blk_addr;
    nwr_data = head_r;
    pwr_en   = 1'b0;
    pwr_addr = head_addr;
    pwr_data = blk_link;
    mset     = 1'b0;
    mclr     = 1'b0;
    mwr_addr = blk_addr;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    ret      = '0;
    status   = idbl_pkg::ST_MISS;
    nx_link  = NULL_LINK;
    pv_link  = NULL_LINK;
    case (idbl_pkg::op_t'(op_r))
      idbl_pkg::OP_PUSH: begin
        if (!pool_hit) begin
          status = idbl_pkg::ST_MISS;
        end else if (member_rd) begin
          status = idbl_pkg::ST_DUP;
        end else begin
          nwr_en = 1'b1;
          if (head_r != NULL_LINK) begin
            pwr_en = 1'b1;
          end else begin
            tail_nxt = blk_link;
          end
          head_nxt = blk_link;
          mset     = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          ret      = blk_r;
          status   = idbl_pkg::ST_OK;
        end
      end
      idbl_pkg::OP_POP: begin
        if (head_r != NULL_LINK) begin
          nx_link  = (head_r == tail_r) ? NULL_LINK : next_rd;
          head_nxt = nx_link;
          if (nx_link == NULL_LINK) begin
            tail_nxt = NULL_LINK;
          end
          mclr     = 1'b1;
          mwr_addr = head_addr;
          cnt_nxt  = cnt_r - CNT_W'(1);
          ret      = idbl_pkg::BLOCK_W'(head_r);
          status   = idbl_pkg::ST_OK;
        end
      end
      idbl_pkg::OP_UNLINK: begin
        if (pool_hit && member_rd) begin
          nx_link = (blk_link == tail_r) ? NULL_LINK : next_rd;
          pv_link = (blk_link == head_r) ? NULL_LINK : prev_rd;
          if (pv_link != NULL_LINK) begin
            nwr_en   = 1'b1;
            nwr_addr = pv_link[ADDR_W-1:0];
            nwr_data = nx_link;
          end else begin
            head_nxt = nx_link;
          end
          if (nx_link != NULL_LINK) begin
            pwr_en   = 1'b1;
            pwr_addr = nx_link[ADDR_W-1:0];
            pwr_data = pv_link;
          end else begin
            tail_nxt = pv_link;
          end
          mclr    = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
          ret     = blk_r;
          status  = idbl_pkg::ST_OK;
        end
      end
      default: begin
        status = idbl_pkg::ST_MISS;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NULL_LINK;
      tail_r      <= NULL_LINK;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (done) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_chan.operation;
      blk_r <= in_chan.block_index;
    end
    if (done) begin
      out_block_r  <= ret;
      out_status_r <= status;
      out_count_r  <= idbl_pkg::COUNT_W'(cnt_nxt);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.returned_block = out_block_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.entry_count    = out_count_r;

  // an accepted beat always moves into the write-back cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted beat did not enter write-back");

  // empty list has both ends null, and only then
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == '0) == (head_r == NULL_LINK)) && ((head_r == NULL_LINK) == (tail_r == NULL_LINK)))
    else $error("count and list ends disagree");

  // a single member is both head and tail
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_W'(1)) |-> (head_r == tail_r))
    else $error("one member but head differs from tail");

  // failed operations report block zero
  a_ret_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != idbl_pkg::ST_OK)) |-> (out_block_r == '0))
    else $error("nonzero block on failed operation");

endmodule

/* design/idbl_link_ram.sv */
// ----------------------------------------------------------------------------
// idbl_link_ram
// Link memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module idbl_link_ram #(
  parameter int DEPTH  = idbl_pkg::POOL_BLOCKS_DEF,
  parameter int DATA_W = 7
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/idbl_member_bits.sv */
// ----------------------------------------------------------------------------
// idbl_member_bits
// One membership flag per block, cleared by reset.
// ----------------------------------------------------------------------------
module idbl_member_bits #(
  parameter int DEPTH = idbl_pkg::POOL_BLOCKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                     rd_bit,
  input  logic                     set_en,
  input  logic                     clr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr
);

  logic [DEPTH-1:0] bits_r;
  logic [DEPTH-1:0] bits_nxt;

  always_comb begin
    bits_nxt = bits_r;
    if (set_en) begin
      bits_nxt[wr_addr] = 1'b1;
    end else if (clr_en) begin
      bits_nxt[wr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
    end else begin
      bits_r <= bits_nxt;
    end
  end

  assign rd_bit = bits_r[rd_addr];

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives push, pop, unlink and unused-code beats into the block list and
// predicts every result from a shadow list of its own. Checks each result
// beat field by field while both channels idle at random in several phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int POOL = idbl_pkg::POOL_BLOCKS_DEF;
  localparam logic [idbl_pkg::COUNT_W-1:0] NO_BLOCK = idbl_pkg::COUNT_W'(POOL);
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEG_ITEMS   = 250;
  localparam logic [idbl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [idbl_pkg::OP_W-1:0]    op;
    logic [idbl_pkg::BLOCK_W-1:0] blk;
  } list_op_t;

  typedef struct {
    logic [idbl_pkg::BLOCK_W-1:0] returned_block;
    idbl_pkg::status_t            status;
    logic [idbl_pkg::COUNT_W-1:0] entry_count;
  } list_result_t;

  logic clk;
  logic rst_n;

  idbl_in_if  in_chan ();
  idbl_out_if out_chan ();

  indexed_doubly_linked_block_list dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // shadow list state
  logic [idbl_pkg::COUNT_W-1:0] next_of [POOL];
  logic [idbl_pkg::COUNT_W-1:0] prev_of [POOL];
  logic                         in_list [POOL];
  logic [idbl_pkg::COUNT_W-1:0] head_at;
  logic [idbl_pkg::COUNT_W-1:0] tail_at;
  logic [idbl_pkg::COUNT_W-1:0] list_count;

  list_op_t     op_queue[$];
  list_result_t pending_results[$];

  int  send_idle   = 0;
  int  recv_stall  = 0;
  int  fail_count  = 0;
  int  cycle_count = 0;
  int  taken_count = 0;
  int  sent_count  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // takes a member block out of the shadow list
  function automatic void drop_block(input logic [idbl_pkg::BLOCK_W-1:0] b);
    logic [idbl_pkg::COUNT_W-1:0] nx;
    logic [idbl_pkg::COUNT_W-1:0] pv;
    nx = next_of[b];
    pv = prev_of[b];
    if (pv != NO_BLOCK) next_of[pv[idbl_pkg::BLOCK_W-1:0]] = nx;
    else head_at = nx;
    if (nx != NO_BLOCK) prev_of[nx[idbl_pkg::BLOCK_W-1:0]] = pv;
    else tail_at = pv;
    next_of[b] = NO_BLOCK;
    prev_of[b] = NO_BLOCK;
    in_list[b] = 1'b0;
    if (list_count != 0) list_count = list_count - 1'b1;
  endfunction

  function automatic void predict_list_op(input logic [idbl_pkg::OP_W-1:0] op,
                                          input logic [idbl_pkg::BLOCK_W-1:0] blk);
    list_result_t                 r;
    logic [idbl_pkg::BLOCK_W-1:0] victim;
    r.returned_block = '0;
    r.status         = idbl_pkg::ST_MISS;
    case (op)
      idbl_pkg::OP_PUSH: begin
        if (in_list[blk]) begin
          r.status = idbl_pkg::ST_DUP;
        end else begin
          prev_of[blk] = NO_BLOCK;
          if (head_at != NO_BLOCK) begin
            next_of[blk] = head_at;
            prev_of[head_at[idbl_pkg::BLOCK_W-1:0]] = idbl_pkg::COUNT_W'(blk);
          end else begin
            next_of[blk] = NO_BLOCK;
            tail_at = idbl_pkg::COUNT_W'(blk);
          end
          head_at          = idbl_pkg::COUNT_W'(blk);
          in_list[blk]     = 1'b1;
          list_count       = list_count + 1'b1;
          r.returned_block = blk;
          r.status         = idbl_pkg::ST_OK;
        end
      end
      idbl_pkg::OP_POP: begin
        if (head_at != NO_BLOCK) begin
          victim           = head_at[idbl_pkg::BLOCK_W-1:0];
          drop_block(victim);
          r.returned_block = victim;
          r.status         = idbl_pkg::ST_OK;
        end
      end
      idbl_pkg::OP_UNLINK: begin
        if (in_list[blk]) begin
          drop_block(blk);
          r.returned_block = blk;
          r.status         = idbl_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    r.entry_count = list_count;
    pending_results.push_back(r);
  endfunction

  // scan from a random block for one with the wanted membership
  function automatic logic [idbl_pkg::BLOCK_W-1:0] pick_block(input logic want_member);
    int start;
    int idx;
    start = $urandom_range(POOL - 1);
    for (int k = 0; k < POOL; k++) begin
      idx = (start + k) % POOL;
      if (in_list[idx] == want_member) return idbl_pkg::BLOCK_W'(idx);
    end
    return idbl_pkg::BLOCK_W'(start);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      head_at    = NO_BLOCK;
      tail_at    = NO_BLOCK;
      list_count = '0;
      for (int i = 0; i < POOL; i++) begin
        next_of[i] = NO_BLOCK;
        prev_of[i] = NO_BLOCK;
        in_list[i] = 1'b0;
      end
    end else if (in_chan.valid && in_chan.ready) begin
      predict_list_op(in_chan.operation, in_chan.block_index);
      taken_count++;
    end
  end

  always @(negedge clk) begin
    list_op_t item;
    if (!rst_n) begin
      in_chan.valid       <= 1'b0;
      in_chan.operation   <= '0;
      in_chan.block_index <= '0;
    end else if (!in_chan.valid || taken_count == sent_count) begin
      if (op_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        item = op_queue.pop_front();
        sent_count++;
        in_chan.valid       <= 1'b1;
        in_chan.operation   <= item.op;
        in_chan.block_index <= item.blk;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  // monitor
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.returned_block !== want.returned_block) begin
          $error("returned_block: expected %0d, actual %0d",
                 want.returned_block, out_chan.returned_block);
          fail_count++;
        end
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_chan.status);
          fail_count++;
        end
        if (out_chan.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 want.entry_count, out_chan.entry_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_op(input logic [idbl_pkg::OP_W-1:0] op,
                          input logic [idbl_pkg::BLOCK_W-1:0] blk);
    list_op_t item;
    item.op  = op;
    item.blk = blk;
    op_queue.push_back(item);
  endtask

  initial begin
    int roll;
    int push_pct;
    int pop_pct;
    int unlink_pct;
    @(posedge rst_n);

    // directed corners
    queue_op(idbl_pkg::OP_POP, 6'd0);        // pop of an empty list
    queue_op(idbl_pkg::OP_UNLINK, 6'd5);     // unlink of a non-member
    queue_op(OP_UNUSED, 6'd0);
    queue_op(idbl_pkg::OP_PUSH, 6'd0);
    queue_op(idbl_pkg::OP_PUSH, 6'd63);
    queue_op(idbl_pkg::OP_PUSH, 6'd0);       // already a member
    queue_op(idbl_pkg::OP_PUSH, 6'd21);
    queue_op(idbl_pkg::OP_PUSH, 6'd42);
    queue_op(idbl_pkg::OP_UNLINK, 6'd21);    // middle of the list
    queue_op(idbl_pkg::OP_UNLINK, 6'd0);     // tail
    queue_op(idbl_pkg::OP_UNLINK, 6'd42);    // head
    queue_op(idbl_pkg::OP_POP, 6'd63);       // last member
    queue_op(idbl_pkg::OP_POP, 6'd63);
    queue_op(OP_UNUSED, 6'd63);
    queue_op(idbl_pkg::OP_UNLINK, 6'd63);
    queue_op(idbl_pkg::OP_PUSH, 6'd7);
    queue_op(idbl_pkg::OP_PUSH, 6'd56);
    queue_op(idbl_pkg::OP_UNLINK, 6'd7);     // tail of two
    queue_op(idbl_pkg::OP_PUSH, 6'd7);
    queue_op(idbl_pkg::OP_POP, 6'd0);
    queue_op(idbl_pkg::OP_POP, 6'd0);
    queue_op(idbl_pkg::OP_UNLINK, 6'd56);

    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 59; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 59; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      // grow, shrink and balanced mixes so the list fills up and drains
      case (seg % 3)
        0: begin push_pct = 70; pop_pct = 10; unlink_pct = 15; end
        1: begin push_pct = 15; pop_pct = 35; unlink_pct = 45; end
        default: begin push_pct = 40; pop_pct = 25; unlink_pct = 30; end
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) begin
        while (op_queue.size() >= 2) @(posedge clk);
        roll = $urandom_range(99);
        if (roll < push_pct)
          queue_op(idbl_pkg::OP_PUSH,
                   ($urandom_range(99) < 85) ? pick_block(1'b0)
                                             : idbl_pkg::BLOCK_W'($urandom_range(POOL - 1)));
        else if (roll < push_pct + pop_pct)
          queue_op(idbl_pkg::OP_POP, idbl_pkg::BLOCK_W'($urandom_range(POOL - 1)));
        else if (roll < push_pct + pop_pct + unlink_pct)
          queue_op(idbl_pkg::OP_UNLINK,
                   ($urandom_range(99) < 80) ? pick_block(1'b1)
                                             : idbl_pkg::BLOCK_W'($urandom_range(POOL - 1)));
        else
          queue_op(OP_UNUSED, idbl_pkg::BLOCK_W'($urandom_range(POOL - 1)));
      end
    end

    while (op_queue.size() != 0 || in_chan.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* indexed_doubly_linked_block_list.f */
design/idbl_pkg.sv
design/idbl_if.sv
design/idbl_link_ram.sv
design/idbl_member_bits.sv
design/indexed_doubly_linked_block_list.sv
verif/tb.sv
